[sv/assert_macros.svh]
// Assertion macros shared by the distance unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that an expression holds at every clock edge outside reset.
`define CEDU_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// Checks that a consequent holds in the cycle after its antecedent.
`define CEDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CEDU_ASSERT(label, expr, msg)
`define CEDU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[sv/cedu_pkg.sv]
// Shared constants and types of the clipped Euclidean distance unit.
package cedu_pkg;

  localparam int ElemWidthDefault = 16;
  localparam int SumW   = 45;
  localparam int RootW  = (SumW + 1) / 2;
  localparam int NumW   = 2 * RootW;
  localparam int ScaleW = 16;
  localparam int DistW  = 30;
  localparam int ProdW  = RootW + ScaleW;
  localparam int CntW   = $clog2(RootW);
  localparam int CfgIdxW = 1;

  localparam logic [DistW-1:0]  ClipReset  = {DistW{1'b1}};
  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(256);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegScale = 1'b0,
    RegClip  = 1'b1
  } reg_index_e;

  // One finished sum of squares moving from the front to the queue.
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
  } sum_beat_t;

  // Queue occupancy as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[sv/clipped_euclidean_distance_unit.sv]
// Top level: accepts one element pair per cycle unless the front stalls on a full queue.
// The front takes magnitude, square and accumulate steps at one pair per cycle while not stalled.
// The back takes one sum from a two-entry queue and computes its root one bit per cycle,
// then multiplies and clips; it takes no new sum until the last result is loaded.
// Reset clears the sum, the queue and the output; the scale register resets to 1.0 and
// the clip register to its maximum.
module clipped_euclidean_distance_unit import cedu_pkg::*; #(
  parameter int ElemWidth = ElemWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ElemWidth-1:0] elem_a_i,
  input  logic [ElemWidth-1:0] elem_b_i,
  input  logic                 last_pair_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DistW-1:0]     distance_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [DistW-1:0]     cfg_data_i
);

  logic [ScaleW-1:0] scale_q;
  logic [DistW-1:0]  clip_q;
  sum_beat_t         push;
  queue_status_t     q_status;
  logic              pop;
  logic [SumW-1:0]   pop_data;

  assign cfg_ready_o = 1'b1;

  // Configuration registers, one beat per write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      clip_q  <= ClipReset;
    end else if (cfg_valid_i) begin
      case (reg_index_e'(cfg_index_i))
        RegScale: scale_q <= cfg_data_i[ScaleW-1:0];
        RegClip:  clip_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cedu_front #(
    .ElemWidth(ElemWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .elem_a_i   (elem_a_i),
    .elem_b_i   (elem_b_i),
    .last_pair_i(last_pair_i),
    .q_status_i (q_status),
    .push_o     (push)
  );

  cedu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop),
    .pop_data_o(pop_data),
    .status_o  (q_status)
  );

  cedu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .scale_i    (scale_q),
    .clip_i     (clip_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .distance_o (distance_o)
  );

endmodule

[sv/cedu_front.sv]
// Front part: takes element pairs and accumulates squared differences.
module cedu_front import cedu_pkg::*; #(
  parameter int ElemWidth = ElemWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ElemWidth-1:0] elem_a_i,
  input  logic [ElemWidth-1:0] elem_b_i,
  input  logic                 last_pair_i,
  input  queue_status_t        q_status_i,
  output sum_beat_t            push_o
);

  localparam int SqW  = 2 * ElemWidth;
  localparam int AccW = ((SqW > SumW) ? SqW : SumW) + 1;

  logic                 advance;
  logic signed [ElemWidth:0] diff;
  logic [ElemWidth-1:0] mag;
  logic [AccW-1:0]      acc;
  logic [SumW-1:0]      sum_sat;

  logic                 s1_valid_q, s1_last_q;
  logic [ElemWidth-1:0] s1_mag_q;
  logic                 s2_valid_q, s2_last_q;
  logic [SqW-1:0]       s2_sq_q;
  logic [SumW-1:0]      sum_q;

  // The pipe holds still only while a finished sum waits for queue space.
  assign advance    = !(s2_valid_q && s2_last_q && q_status_i.full);
  assign in_ready_o = advance;

  // Magnitude of the signed difference always fits the element width.
  assign diff = $signed({elem_a_i[ElemWidth-1], elem_a_i})
              - $signed({elem_b_i[ElemWidth-1], elem_b_i});
  always_comb begin
    if (diff[ElemWidth]) begin
      mag = ElemWidth'(-diff);
    end else begin
      mag = diff[ElemWidth-1:0];
    end
  end

  // Saturating accumulation of the square.
  assign acc = AccW'(sum_q) + AccW'(s2_sq_q);
  assign sum_sat = (acc[AccW-1:SumW] != '0) ? {SumW{1'b1}} : acc[SumW-1:0];

  assign push_o.valid = advance && s2_valid_q && s2_last_q;
  assign push_o.sum   = sum_sat;

  // Pipeline control state and the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      sum_q      <= '0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        sum_q <= s2_last_q ? '0 : sum_sat;
      end
    end
  end

  // Payload stages: magnitude, then square.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_mag_q  <= mag;
      s1_last_q <= last_pair_i;
      s2_sq_q   <= SqW'(s1_mag_q) * SqW'(s1_mag_q);
      s2_last_q <= s1_last_q;
    end
  end

endmodule

[sv/cedu_queue.sv]
// Two-entry queue of finished sums between the front and the back.
`include "assert_macros.svh"
module cedu_queue import cedu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sum_beat_t       push_i,
  input  logic            pop_i,
  output logic [SumW-1:0] pop_data_o,
  output queue_status_t   status_o
);

  logic [SumW-1:0] mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i.valid && pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.sum;
    end
  end

  `CEDU_ASSERT(a_no_push_full, !(push_i.valid && status_o.full), "push into full queue")
  `CEDU_ASSERT(a_no_pop_empty, !(pop_i && status_o.empty), "pop from empty queue")
  `CEDU_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")

endmodule

[sv/cedu_back.sv]
// Back part: integer square root, scaling, clipping and the output register.
`include "assert_macros.svh"
module cedu_back import cedu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  queue_status_t     q_status_i,
  input  logic [SumW-1:0]   pop_data_i,
  output logic              pop_o,
  input  logic [ScaleW-1:0] scale_i,
  input  logic [DistW-1:0]  clip_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DistW-1:0]  distance_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRoot,
    StMul,
    StClip
  } state_e;

  localparam int RemW = RootW + 2;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic [NumW-1:0]  num_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [ProdW-1:0] prod_q;
  logic             out_valid_q;
  logic [DistW-1:0] dist_q;

  logic [RemW-1:0]    rem_sh, trial;
  logic               fits;
  logic [ProdW-9:0]   scaled;
  logic [DistW-1:0]   clipped;
  logic               out_free;
  logic               out_load;

  assign pop_o       = (state_q == StIdle) && !q_status_i.empty;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == StClip) && out_free;
  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

  // One root digit per cycle: bring down two bits and try the next root bit.
  assign rem_sh = {rem_q[RootW-1:0], num_q[NumW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  // Drop the fraction bits of the scaled root and bound it by the clip limit.
  assign scaled  = prod_q[ProdW-1:8];
  assign clipped = (scaled > (ProdW-8)'(clip_i)) ? clip_i : scaled[DistW-1:0];

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new beat replaces the one leaving in the same cycle.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (!q_status_i.empty) begin
            cnt_q   <= CntW'(RootW - 1);
            state_q <= StRoot;
          end
        end
        StRoot: begin
          if (cnt_q == '0) begin
            state_q <= StMul;
          end else begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        StMul: begin
          state_q <= StClip;
        end
        StClip: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        num_q  <= NumW'(pop_data_i);
        rem_q  <= '0;
        root_q <= '0;
      end
      StRoot: begin
        num_q  <= {num_q[NumW-3:0], 2'b00};
        rem_q  <= fits ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[RootW-2:0], fits};
      end
      StMul: begin
        prod_q <= ProdW'(root_q) * ProdW'(scale_i);
      end
      StClip: begin
        if (out_free) begin
          dist_q <= clipped;
        end
      end
      default: begin
      end
    endcase
  end

  `CEDU_ASSERT(a_pop_idle, !pop_o || (state_q == StIdle), "pop while back is busy")
  `CEDU_ASSERT(a_out_clip, !out_valid_q || (dist_q <= clip_i), "distance above clip limit")
  `CEDU_ASSERT_NEXT(a_mul_then_clip, state_q == StMul, state_q == StClip,
                    "multiply not followed by clip")

endmodule
